### rtl/prq_pkg.sv
`timescale 1ns / 1ps

package prq_pkg;

    localparam int IN_W   = 16;
    localparam int OUT_W  = 8;
    localparam int TASK_W = 6;
    localparam int PRIO_W = 5;

    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    typedef enum logic {
        FN_ENQ = 1'b0,
        FN_DEQ = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LVL,
        S_NXT
    } t_state;

    typedef enum logic {
        OP_INC,
        OP_DEC
    } t_cnt_op;

    typedef struct packed {
        logic full;
        logic last;
    } t_cnt_flags;

endpackage

### rtl/prq_ram.sv
`timescale 1ns / 1ps

module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/prq_cnt_unit.sv
`timescale 1ns / 1ps

module prq_cnt_unit #(
    parameter int TASKS = 64,
    parameter int CW    = $clog2(TASKS + 1)
) (
    input  prq_pkg::t_cnt_op    i_op,
    input  logic [CW-1:0]       i_count,
    output logic [CW-1:0]       o_result,
    output prq_pkg::t_cnt_flags o_flags
);

    assign o_result = (i_op == prq_pkg::OP_INC) ? i_count + CW'(1) : i_count - CW'(1);
    assign o_flags.full = (32'(i_count) >= TASKS);
    assign o_flags.last = (i_count == CW'(1));

endmodule

### rtl/prq_prio_enc.sv
`timescale 1ns / 1ps

module prq_prio_enc #(
    parameter int LEVELS = 32,
    parameter int LW     = $clog2(LEVELS)
) (
    input  logic [LEVELS-1:0] i_mask,
    output logic [LW-1:0]     o_level,
    output logic              o_any
);

    // Level zero is never marked, so the search starts at level one.
    always_comb begin
        o_level = '0;
        o_any   = 1'b0;
        for (int i = LEVELS - 1; i >= 1; i--) begin
            if (i_mask[i]) begin
                o_level = LW'(i);
                o_any   = 1'b1;
            end
        end
    end

endmodule

### rtl/priority_ready_queue_scheduler.sv
`timescale 1ns / 1ps
// An input word is accepted only in the idle state; its result word is loaded into the output
// register from the S_LVL state once that register is free.
// An enqueue or an empty or final dequeue occupies the block in S_LVL only, any other dequeue in
// S_LVL and then S_NXT, set by the registered reads of the level pointers and then of the task link memory.
// Reset is synchronous and active low: it clears the ready bitmap, the sequencer and the output
// valid flag; the pointer, count and link memories are not cleared.
module priority_ready_queue_scheduler #(
    parameter int LEVELS = 32,
    parameter int TASKS  = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // func [0], task_id [6:1], priority_req [11:7], zero fill [15:12].
    input  logic [prq_pkg::IN_W-1:0]   i_s_tdata,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // status [1:0], out_task [7:2].
    output logic [prq_pkg::OUT_W-1:0]  o_m_tdata
);

    localparam int LW = $clog2(LEVELS);
    localparam int TW = $clog2(TASKS);
    localparam int CW = $clog2(TASKS + 1);

    prq_pkg::t_state     r_state, n_state;
    logic [LEVELS-1:0]   r_mask, n_mask;
    logic                r_m_tvalid, n_m_tvalid;
    logic [prq_pkg::OUT_W-1:0] r_m_tdata, n_m_tdata;

    prq_pkg::t_func      r_func;
    logic [TW-1:0]       r_task;
    logic [LW-1:0]       r_level;
    logic                r_bad;
    logic                r_none;

    prq_pkg::t_func              in_func;
    logic [prq_pkg::TASK_W-1:0]  in_task;
    logic [prq_pkg::PRIO_W-1:0]  in_prio;
    logic                        in_bad;
    logic                        accept;
    logic                        out_free;
    logic [LW-1:0]               enc_level;
    logic                        enc_any;
    logic [LW-1:0]               acc_level;
    logic [LW-1:0]               lvl_rd_addr;

    logic [TW-1:0]  head_rd, tail_rd, next_rd, head_wd;
    logic [CW-1:0]  cnt_rd, cnt_q, cnt_res;
    logic           head_we, tail_we, cnt_we, next_we;
    prq_pkg::t_cnt_op    cnt_op;
    prq_pkg::t_cnt_flags cnt_flags;

    assign in_func = prq_pkg::t_func'(i_s_tdata[0]);
    assign in_task = i_s_tdata[6:1];
    assign in_prio = i_s_tdata[11:7];
    assign in_bad  = (in_prio == '0) || (32'(in_prio) >= LEVELS) || (32'(in_task) >= TASKS);

    assign o_s_tready = (r_state == prq_pkg::S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_tvalid || i_m_tready;

    assign acc_level   = (in_func == prq_pkg::FN_ENQ) ? LW'(in_prio) : enc_level;
    assign lvl_rd_addr = (r_state == prq_pkg::S_IDLE) ? acc_level : r_level;
    assign cnt_q       = r_mask[r_level] ? cnt_rd : '0;
    assign cnt_op      = (r_func == prq_pkg::FN_ENQ) ? prq_pkg::OP_INC : prq_pkg::OP_DEC;
    assign head_wd     = (r_state == prq_pkg::S_NXT) ? next_rd : r_task;

    prq_prio_enc #(.LEVELS(LEVELS), .LW(LW)) u_enc (
        .i_mask  (r_mask),
        .o_level (enc_level),
        .o_any   (enc_any)
    );

    prq_cnt_unit #(.TASKS(TASKS), .CW(CW)) u_cnt_unit (
        .i_op     (cnt_op),
        .i_count  (cnt_q),
        .o_result (cnt_res),
        .o_flags  (cnt_flags)
    );

    prq_ram #(.WIDTH(TW), .DEPTH(LEVELS)) u_head_ram (
        .i_clk     (i_clk),
        .i_wr_en   (head_we),
        .i_wr_addr (r_level),
        .i_wr_data (head_wd),
        .i_rd_addr (lvl_rd_addr),
        .o_rd_data (head_rd)
    );

    prq_ram #(.WIDTH(TW), .DEPTH(LEVELS)) u_tail_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tail_we),
        .i_wr_addr (r_level),
        .i_wr_data (r_task),
        .i_rd_addr (lvl_rd_addr),
        .o_rd_data (tail_rd)
    );

    prq_ram #(.WIDTH(CW), .DEPTH(LEVELS)) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cnt_we),
        .i_wr_addr (r_level),
        .i_wr_data (cnt_res),
        .i_rd_addr (lvl_rd_addr),
        .o_rd_data (cnt_rd)
    );

    prq_ram #(.WIDTH(TW), .DEPTH(TASKS)) u_next_ram (
        .i_clk     (i_clk),
        .i_wr_en   (next_we),
        .i_wr_addr (tail_rd),
        .i_wr_data (r_task),
        .i_rd_addr (head_rd),
        .o_rd_data (next_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= prq_pkg::S_IDLE;
            r_mask     <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mask     <= n_mask;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_tdata <= n_m_tdata;
        if (accept) begin
            r_func  <= in_func;
            r_task  <= TW'(in_task);
            r_level <= acc_level;
            r_bad   <= in_bad;
            r_none  <= !enc_any;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_mask     = r_mask;
        n_m_tvalid = r_m_tvalid && !i_m_tready;
        n_m_tdata  = r_m_tdata;
        head_we    = 1'b0;
        tail_we    = 1'b0;
        cnt_we     = 1'b0;
        next_we    = 1'b0;
        unique case (r_state)
            prq_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = prq_pkg::S_LVL;
                end
            end
            prq_pkg::S_LVL: begin
                if (out_free) begin
                    n_m_tvalid = 1'b1;
                    n_state    = prq_pkg::S_IDLE;
                    if (r_func == prq_pkg::FN_ENQ) begin
                        if (r_bad || cnt_flags.full) begin
                            n_m_tdata = {6'b0, prq_pkg::ST_BAD};
                        end else begin
                            head_we         = (cnt_q == '0);
                            next_we         = (cnt_q != '0);
                            tail_we         = 1'b1;
                            cnt_we          = 1'b1;
                            n_mask[r_level] = 1'b1;
                            n_m_tdata       = {6'b0, prq_pkg::ST_ENQ};
                        end
                    end else if (r_none) begin
                        n_m_tdata = {6'b0, prq_pkg::ST_EMPTY};
                    end else begin
                        n_m_tdata = {6'(head_rd), prq_pkg::ST_DEQ};
                        cnt_we    = 1'b1;
                        if (cnt_flags.last) begin
                            n_mask[r_level] = 1'b0;
                        end else begin
                            n_state = prq_pkg::S_NXT;
                        end
                    end
                end
            end
            prq_pkg::S_NXT: begin
                head_we = 1'b1;
                n_state = prq_pkg::S_IDLE;
            end
            default: begin
                n_state = prq_pkg::S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

endmodule

### rtl/prq_checker.sv
`timescale 1ns / 1ps

module prq_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_tvalid,
    input logic                      o_s_tready,
    input logic [prq_pkg::IN_W-1:0]  i_s_tdata,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready,
    input logic [prq_pkg::OUT_W-1:0] o_m_tdata
);

    // Reset leaves no result word pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result word valid after reset");

    // A held result word keeps its value until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed while stalled");

    // The block is busy in the cycle after it takes a word.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second word taken while busy");

    // A new result appears only while a request is being processed.
    a_result_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(o_s_tready))
        else $error("result word without a request");

    // A dequeue that reports no ready task carries a zero task number.
    a_empty_task_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] == prq_pkg::ST_EMPTY) |-> (o_m_tdata[7:2] == '0))
        else $error("empty result carries a task number");

endmodule

bind priority_ready_queue_scheduler prq_checker u_prq_checker (.*);

### tb/priority_ready_queue_scheduler_tb.sv
`timescale 1ns / 1ps

module priority_ready_queue_scheduler_tb;

    localparam int LEVELS = 32;
    localparam int TASKS  = 64;

    typedef struct packed {
        logic [3:0]                 pad;
        logic [prq_pkg::PRIO_W-1:0] prio;
        logic [prq_pkg::TASK_W-1:0] tid;
        prq_pkg::t_func             func;
    } t_sched_req;

    typedef struct packed {
        logic [prq_pkg::TASK_W-1:0] out_task;
        prq_pkg::t_status           status;
    } t_sched_result;

    logic                      i_clk    = 1'b0;
    logic                      i_rst_n  = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [prq_pkg::IN_W-1:0]  s_tdata  = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [prq_pkg::OUT_W-1:0] m_tdata;

    priority_ready_queue_scheduler #(
        .LEVELS(LEVELS),
        .TASKS (TASKS)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata)
    );

    // Shadow copy of the ready queue.
    logic [LEVELS-1:0]           rq_mask = '0;
    logic [prq_pkg::TASK_W-1:0]  rq_head [LEVELS];
    logic [prq_pkg::TASK_W-1:0]  rq_tail [LEVELS];
    int unsigned                 rq_count[LEVELS];
    logic [prq_pkg::TASK_W-1:0]  rq_link [TASKS];
    int                          queued_cnt[TASKS];
    int                          max_fill = 0;

    t_sched_req    pending_reqs[$];
    t_sched_result expected_results[$];

    int errors    = 0;
    int n_enq     = 0;
    int n_deq     = 0;
    int n_empty   = 0;
    int n_bad     = 0;
    int burst_left = 1;
    int gap_left   = 0;
    int rx_cycle   = 0;
    int rx_mode    = 0;
    int hold_left  = 0;
    int holds_done = 0;

    function automatic t_sched_result schedule_request(t_sched_req rq);
        t_sched_result r;
        int unsigned   lv;
        logic [prq_pkg::TASK_W-1:0] h;
        r.out_task = '0;
        if (rq.func == prq_pkg::FN_ENQ) begin
            if (rq.prio == 0 || rq_count[rq.prio] >= TASKS) begin
                r.status = prq_pkg::ST_BAD;
            end else begin
                if (rq_count[rq.prio] == 0) begin
                    rq_head[rq.prio] = rq.tid;
                end else begin
                    rq_link[rq_tail[rq.prio]] = rq.tid;
                end
                rq_tail[rq.prio] = rq.tid;
                rq_count[rq.prio]++;
                rq_mask[rq.prio] = 1'b1;
                if (rq_count[rq.prio] > max_fill) begin
                    max_fill = rq_count[rq.prio];
                end
                r.status = prq_pkg::ST_ENQ;
            end
        end else begin
            lv = LEVELS;
            for (int l = LEVELS - 1; l >= 1; l--) begin
                if (rq_mask[l]) begin
                    lv = l;
                end
            end
            if (lv == LEVELS) begin
                r.status = prq_pkg::ST_EMPTY;
            end else begin
                h = rq_head[lv];
                r.out_task = h;
                if (rq_count[lv] > 1) begin
                    rq_head[lv] = rq_link[h];
                end
                rq_count[lv]--;
                if (rq_count[lv] == 0) begin
                    rq_mask[lv] = 1'b0;
                end
                r.status = prq_pkg::ST_DEQ;
            end
        end
        return r;
    endfunction

    task automatic push_req(input prq_pkg::t_func func, input int tid, input int prio);
        t_sched_req    rq;
        t_sched_result r;
        rq.pad  = '0;
        rq.func = func;
        rq.tid  = tid[prq_pkg::TASK_W-1:0];
        rq.prio = prio[prq_pkg::PRIO_W-1:0];
        r = schedule_request(rq);
        if (r.status == prq_pkg::ST_ENQ) begin
            queued_cnt[rq.tid]++;
        end else if (r.status == prq_pkg::ST_DEQ) begin
            queued_cnt[r.out_task]--;
        end
        pending_reqs.push_back(rq);
        expected_results.push_back(r);
    endtask

    task automatic push_deq();
        push_req(prq_pkg::FN_DEQ, $urandom_range(0, TASKS - 1), $urandom_range(0, LEVELS - 1));
    endtask

    function automatic int pick_free_task();
        int start;
        int t;
        start = $urandom_range(0, TASKS - 1);
        for (int k = 0; k < TASKS; k++) begin
            t = (start + k) % TASKS;
            if (queued_cnt[t] == 0) begin
                return t;
            end
        end
        return start;
    endfunction

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Timeout at %0t", $time);
        $display("Test completed with failures");
        $finish;
    end

    // Sender: bursts of words separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                s_tdata  <= pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: changing stall patterns plus long hold-offs that back up the input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_cycle % 4000 == 1500) begin
                hold_left = 400;
                holds_done++;
                m_tready <= 1'b0;
            end else begin
                if (rx_cycle % 97 == 0) begin
                    rx_mode = $urandom_range(0, 3);
                end
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (rx_cycle % 5 != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_sched_result act;
        t_sched_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            act = m_tdata;
            case (act.status)
                prq_pkg::ST_ENQ:   n_enq++;
                prq_pkg::ST_DEQ:   n_deq++;
                prq_pkg::ST_EMPTY: n_empty++;
                default:           n_bad++;
            endcase
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, status %0d task %0d",
                         $time, act.status, act.out_task);
            end else begin
                want = expected_results.pop_front();
                if (act.status !== want.status) begin
                    errors++;
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, act.status);
                end
                if (act.out_task !== want.out_task) begin
                    errors++;
                    $display("%0t: out_task mismatch, expected %0d actual %0d",
                             $time, want.out_task, act.out_task);
                end
            end
        end
    end

    initial begin
        int order[TASKS];
        int tmp;
        int j;
        int enq_pct;
        int prio;
        int tid;
        int wait_cycles;

        for (int l = 0; l < LEVELS; l++) begin
            rq_head[l]  = '0;
            rq_tail[l]  = '0;
            rq_count[l] = 0;
        end
        for (int t = 0; t < TASKS; t++) begin
            rq_link[t]    = '0;
            queued_cnt[t] = 0;
        end

        // Directed part: empty queue, invalid priority, extremes, ordering, duplicates.
        push_req(prq_pkg::FN_DEQ, 63, 31);
        push_req(prq_pkg::FN_ENQ, 63, 0);
        push_req(prq_pkg::FN_ENQ, 0, 31);
        push_req(prq_pkg::FN_ENQ, 63, 1);
        push_req(prq_pkg::FN_ENQ, 42, 1);
        push_req(prq_pkg::FN_ENQ, 21, 16);
        push_req(prq_pkg::FN_ENQ, 0, 0);
        push_req(prq_pkg::FN_DEQ, 0, 0);
        push_req(prq_pkg::FN_DEQ, 63, 31);
        push_req(prq_pkg::FN_DEQ, 21, 10);
        push_req(prq_pkg::FN_DEQ, 42, 1);
        push_req(prq_pkg::FN_DEQ, 0, 0);
        push_req(prq_pkg::FN_ENQ, 5, 3);
        push_req(prq_pkg::FN_ENQ, 5, 3);
        push_req(prq_pkg::FN_DEQ, 0, 0);
        push_req(prq_pkg::FN_DEQ, 0, 0);
        push_req(prq_pkg::FN_DEQ, 0, 0);

        // Fill one level to capacity, try one more, then drain it.
        for (int t = 0; t < TASKS; t++) begin
            order[t] = t;
        end
        for (int t = TASKS - 1; t > 0; t--) begin
            j = $urandom_range(0, t);
            tmp = order[t];
            order[t] = order[j];
            order[j] = tmp;
        end
        for (int t = 0; t < TASKS; t++) begin
            push_req(prq_pkg::FN_ENQ, order[t], 31);
        end
        push_req(prq_pkg::FN_ENQ, order[0], 31);
        for (int t = 0; t <= TASKS; t++) begin
            push_deq();
        end

        // Random part with phases of growing and shrinking occupancy.
        enq_pct = 60;
        for (int n = 0; n < 1300; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 3))
                    0: enq_pct = 80;
                    1: enq_pct = 50;
                    2: enq_pct = 25;
                    default: enq_pct = 60;
                endcase
            end
            if ($urandom_range(0, 99) < enq_pct) begin
                if ($urandom_range(0, 99) < 3) begin
                    prio = 0;
                end else if ($urandom_range(0, 2) == 0) begin
                    case ($urandom_range(0, 2))
                        0: prio = 1;
                        1: prio = 2;
                        default: prio = 31;
                    endcase
                end else begin
                    prio = $urandom_range(1, LEVELS - 1);
                end
                if ($urandom_range(0, 99) < 3) begin
                    tid = $urandom_range(0, TASKS - 1);
                end else begin
                    tid = pick_free_task();
                end
                push_req(prq_pkg::FN_ENQ, tid, prio);
            end else begin
                push_deq();
            end
        end
        while (rq_mask != 0) begin
            push_deq();
        end
        push_deq();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0) begin
            @(posedge i_clk);
        end
        wait_cycles = 20;
        repeat (wait_cycles) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
        end

        $display("Run covered %0d enqueues, %0d dequeues, %0d empty dequeues, %0d refusals.",
                 n_enq, n_deq, n_empty, n_bad);
        $display("Deepest level held %0d tasks; %0d long receiver hold-offs applied.",
                 max_fill, holds_done);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
rtl/prq_pkg.sv
rtl/prq_ram.sv
rtl/prq_cnt_unit.sv
rtl/prq_prio_enc.sv
rtl/priority_ready_queue_scheduler.sv
rtl/prq_checker.sv
tb/priority_ready_queue_scheduler_tb.sv
